@@ sv/box_average_3x3_stencil_top_assert.svh @@
// Assertion macros shared by the 3x3 box-average modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BOX_AVERAGE_3X3_STENCIL_TOP_ASSERT_SVH
`define BOX_AVERAGE_3X3_STENCIL_TOP_ASSERT_SVH

// Antecedent true now implies consequent true in the same cycle.
`define BAV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent true now implies consequent true in the next cycle.
`define BAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bav_pkg.sv @@
// Shared types and constants of the 3x3 box-average stencil.
// No dependencies; imported by every module of the block.
package bav_pkg;

   localparam int SAMPLE_BITS       = 24;
   localparam int SUM_BITS          = SAMPLE_BITS + 4;
   localparam int MAG_BITS          = SAMPLE_BITS + 3;
   localparam int ROW_BITS          = 16;
   localparam int COL_BITS          = 10;
   localparam int WIDTH_REG_BITS    = 11;
   localparam int HEIGHT_REG_BITS   = 16;
   localparam int CSR_DATA_BITS     = 16;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int WINDOW_CELLS      = 6;
   localparam int MIN_FRAME         = 3;
   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam logic [WIDTH_REG_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_BITS-1:0] FRAME_HEIGHT_RESET = 16'd1024;

   // ceil(2^31 / 9): exact quotient for every magnitude below 2^31 / 7
   localparam int RECIP_BITS  = 28;
   localparam int RECIP_SHIFT = 31;
   localparam logic [RECIP_BITS-1:0] RECIP_NINE = 28'd238609295;
   localparam logic [MAG_BITS-1:0]   ROUND_HALF = MAG_BITS'(4);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One cell's work handed from the window stage to the result stage
   typedef struct packed {
      logic signed [SUM_BITS-1:0]    sum;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [ROW_BITS-1:0]           row;
      logic [COL_BITS-1:0]           col;
      logic                          mean_due;
      logic                          border;
      logic                          last;
   } job_type;

endpackage

@@ sv/bav_line_buf.sv @@
// One line buffer: single write port, single registered read port.
// Depends on bav_pkg for the sample width.
`include "box_average_3x3_stencil_top_assert.svh"
module bav_line_buf #(
   parameter int DEPTH = bav_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [bav_pkg::SAMPLE_BITS-1:0]     wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [bav_pkg::SAMPLE_BITS-1:0]     rd_data
);
   import bav_pkg::*;

   logic [SAMPLE_BITS-1:0] mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bav_front.sv @@
// Frame counters, configuration registers, input stage, line buffers,
// 3x3 window and nine-sample sum. Depends on bav_pkg and bav_line_buf.
`include "box_average_3x3_stencil_top_assert.svh"
module bav_front #(
   parameter int MAX_WIDTH = bav_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [bav_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [bav_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [bav_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                   job_valid,
   output bav_pkg::job_type                       job,
   input  logic                                   job_take
);
   import bav_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [WIDTH_REG_BITS-1:0]  frame_width_ff;
   logic [HEIGHT_REG_BITS-1:0] frame_height_ff;
   logic [31:0]                width_eff;
   logic [COL_W-1:0]           width_last;
   logic [ROW_BITS-1:0]        height_last;

   logic [ROW_BITS-1:0] row_ff;
   logic [COL_W-1:0]    col_ff;

   logic                          a_valid_ff;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic [ROW_BITS-1:0]           a_row_ff;
   logic [COL_W-1:0]              a_col_ff;
   logic signed [SAMPLE_BITS-1:0] up2;
   logic signed [SAMPLE_BITS-1:0] up1;
   logic signed [SAMPLE_BITS-1:0] win_ff [WINDOW_CELLS];
   logic signed [SUM_BITS-1:0]    sum_in;

   logic    b_valid_ff;
   job_type b_job_ff;
   job_type b_job_in;

   logic accept;
   logic a_move;
   logic b_free;

   // Effective frame size after clamping
   always_comb begin
      width_eff = 32'(frame_width_ff);
      if (width_eff < 32'(MIN_FRAME)) begin
         width_eff = 32'(MIN_FRAME);
      end
      if (width_eff > 32'(MAX_WIDTH)) begin
         width_eff = 32'(MAX_WIDTH);
      end
      width_last = COL_W'(width_eff - 32'd1);
      if (frame_height_ff < HEIGHT_REG_BITS'(MIN_FRAME)) begin
         height_last = ROW_BITS'(MIN_FRAME - 1);
      end else begin
         height_last = frame_height_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign b_free    = !b_valid_ff || job_take;
   assign a_move    = a_valid_ff && b_free;
   assign req_ready = !a_valid_ff || b_free;
   assign accept    = req_valid && req_ready;

   // Raster position of the next sample; a configuration write restarts the frame
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (col_ff == width_last) begin
            col_ff <= '0;
            row_ff <= (row_ff == height_last) ? '0 : row_ff + 16'd1;
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sample_ff <= req_sample_in;
         a_row_ff    <= row_ff;
         a_col_ff    <= col_ff;
      end
   end

   // Read the column at acceptance, write it back when the cell leaves the stage
   bav_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_two (
      .clock   (clock),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data (up1),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up2)
   );

   bav_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_one (
      .clock   (clock),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data (a_sample_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up1)
   );

   // Window rows: cells 0..1 two above, 2..3 one above, 4..5 current
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_CELLS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (a_move) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= up2;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= up1;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= a_sample_ff;
      end
   end

   assign sum_in = SUM_BITS'(win_ff[0]) + SUM_BITS'(win_ff[1]) + SUM_BITS'(up2)
                 + SUM_BITS'(win_ff[2]) + SUM_BITS'(win_ff[3]) + SUM_BITS'(up1)
                 + SUM_BITS'(win_ff[4]) + SUM_BITS'(win_ff[5])
                 + SUM_BITS'(a_sample_ff);

   always_comb begin
      b_job_in.sum      = sum_in;
      b_job_in.sample   = a_sample_ff;
      b_job_in.row      = a_row_ff;
      b_job_in.col      = COL_BITS'(a_col_ff);
      b_job_in.mean_due = (a_row_ff >= 16'd2) && (a_col_ff >= COL_W'(2));
      b_job_in.border   = (a_row_ff == '0) || (a_row_ff == height_last)
                       || (a_col_ff == '0) || (a_col_ff == width_last);
      b_job_in.last     = (a_row_ff == height_last) && (a_col_ff == width_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_move) begin
         b_valid_ff <= 1'b1;
      end else if (job_take) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_job_ff <= b_job_in;
      end
   end

   assign job_valid = b_valid_ff;
   assign job       = b_job_ff;

   `BAV_ASSERT_NOW(a_col_in_range, clock, reset, 1'b1, col_ff <= width_last, "column counter past frame width")
   `BAV_ASSERT_NEXT(a_stage_hold, clock, reset, a_valid_ff && !b_free, a_valid_ff && $stable(a_col_ff), "input stage lost its cell under stall")
   `BAV_ASSERT_NEXT(a_accept_fills, clock, reset, accept, a_valid_ff, "accepted sample did not reach the input stage")

endmodule

@@ sv/bav_result.sv @@
// Divide-by-nine rounding, result drain and output register.
// Depends on bav_pkg; takes jobs from bav_front.
`include "box_average_3x3_stencil_top_assert.svh"
module bav_result (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    job_valid,
   input  bav_pkg::job_type                        job,
   output logic                                    job_take,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bav_pkg::SAMPLE_BITS-1:0]  rsp_value_out,
   output logic [bav_pkg::ROW_BITS-1:0]            rsp_row_out,
   output logic [bav_pkg::COL_BITS-1:0]            rsp_col_out,
   output logic                                    rsp_frame_done
);
   import bav_pkg::*;

   localparam int PROD_BITS = MAG_BITS + RECIP_BITS;

   logic [SUM_BITS-1:0]    sum_abs;
   logic [MAG_BITS-1:0]    mag_round;
   logic [PROD_BITS-1:0]   product;

   logic                          c_valid_ff;
   logic [SAMPLE_BITS-1:0]        c_quot_ff;
   logic                          c_neg_ff;
   logic signed [SAMPLE_BITS-1:0] c_sample_ff;
   logic [ROW_BITS-1:0]           c_row_ff;
   logic [COL_BITS-1:0]           c_col_ff;
   logic                          c_mean_ff;
   logic                          c_border_ff;
   logic                          c_last_ff;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   logic [ROW_BITS-1:0]           rsp_row_ff;
   logic [COL_BITS-1:0]           rsp_col_ff;
   logic                          rsp_frame_done_ff;

   logic                          out_free;
   logic                          c_two;
   logic                          c_any;
   logic                          c_pop;
   logic                          c_done;
   logic                          c_free;
   logic                          c_load;
   logic signed [SAMPLE_BITS-1:0] mean_value;

   // Round half away from zero on the magnitude, then multiply by 1/9
   assign sum_abs   = job.sum[SUM_BITS-1] ? SUM_BITS'(-job.sum) : SUM_BITS'(job.sum);
   assign mag_round = MAG_BITS'(sum_abs) + ROUND_HALF;
   assign product   = PROD_BITS'(mag_round) * PROD_BITS'(RECIP_NINE);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign c_two    = c_mean_ff && c_border_ff;
   assign c_any    = c_mean_ff || c_border_ff;
   assign c_pop    = c_valid_ff && c_any && out_free;
   // A cell with no result leaves at once; one with two takes two pops
   assign c_done   = c_valid_ff && !c_two && (out_free || !c_any);
   assign c_free   = !c_valid_ff || c_done;
   assign c_load   = job_valid && c_free;
   assign job_take = c_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_load) begin
         c_valid_ff <= 1'b1;
      end else if (c_done) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_quot_ff   <= product[RECIP_SHIFT +: SAMPLE_BITS];
         c_neg_ff    <= job.sum[SUM_BITS-1];
         c_sample_ff <= job.sample;
         c_row_ff    <= job.row;
         c_col_ff    <= job.col;
         c_mean_ff   <= job.mean_due;
         c_border_ff <= job.border;
         c_last_ff   <= job.last;
      end else if (c_pop && c_mean_ff) begin
         // drop the mean once issued, the pass-through follows
         c_mean_ff <= 1'b0;
      end
   end

   assign mean_value = c_neg_ff ? SAMPLE_BITS'(-c_quot_ff) : SAMPLE_BITS'(c_quot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_pop) begin
         if (c_mean_ff) begin
            rsp_value_ff      <= mean_value;
            rsp_row_ff        <= c_row_ff - 16'd1;
            rsp_col_ff        <= c_col_ff - COL_BITS'(1);
            rsp_frame_done_ff <= 1'b0;
         end else begin
            rsp_value_ff      <= c_sample_ff;
            rsp_row_ff        <= c_row_ff;
            rsp_col_ff        <= c_col_ff;
            rsp_frame_done_ff <= c_last_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_row_out    = rsp_row_ff;
   assign rsp_col_out    = rsp_col_ff;
   assign rsp_frame_done = rsp_frame_done_ff;

   `BAV_ASSERT_NEXT(a_two_drain, clock, reset, c_pop && c_two, c_valid_ff && !c_mean_ff && c_border_ff, "two-result cell did not keep its pass-through")
   `BAV_ASSERT_NEXT(a_mean_not_last, clock, reset, c_pop && c_mean_ff, !rsp_frame_done_ff, "mean result marked as end of frame")

endmodule

@@ sv/box_average_3x3_stencil_top.sv @@
// Top level of the 3x3 box-average stencil over a raster-ordered frame.
// Depends on bav_pkg, bav_front, bav_result and bav_line_buf.
//
// Samples (signed Q16.8) enter one per clock in raster order while req_ready
// is high. Each interior cell gets the rounded mean of its 3x3 neighborhood,
// issued when its lower-right neighbor arrives; border cells are passed
// through on arrival, and the last cell of the frame carries frame_done. The
// result stage issues one result per cycle unless rsp_ready stalls it, so a
// sample that yields two results (the last column of every row from row 2
// on, and columns 2 and up of the last row) holds the input back while both
// issue. Each sample passes the input register with line-buffer read,
// window sum, 1/9 multiply and output register. The two line buffers are
// MAX_WIDTH-deep RAMs with one write and one read per cycle and need no
// clearing after reset. Configuration writes restart the frame at row 0,
// column 0; the user must make them while idle, unenforced by the block.
module box_average_3x3_stencil_top #(
   parameter int MAX_WIDTH = bav_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [bav_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [bav_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [bav_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bav_pkg::SAMPLE_BITS-1:0] rsp_value_out,
   output logic [bav_pkg::ROW_BITS-1:0]           rsp_row_out,
   output logic [bav_pkg::COL_BITS-1:0]           rsp_col_out,
   output logic                                   rsp_frame_done
);
   import bav_pkg::*;

   logic    job_valid;
   job_type job;
   logic    job_take;

   bav_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .job_valid     (job_valid),
      .job           (job),
      .job_take      (job_take)
   );

   bav_result u_result (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job            (job),
      .job_take       (job_take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_out  (rsp_value_out),
      .rsp_row_out    (rsp_row_out),
      .rsp_col_out    (rsp_col_out),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule
